>>> rtl/qpe_pkg.sv
`default_nettype none

package qpe_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned HashW        = $clog2(TableEntries);
  localparam int unsigned MaxRun       = 62;
  localparam int unsigned RunW         = 6;
  localparam int unsigned MaxBytes     = 14;
  localparam int unsigned CntW         = $clog2(MaxBytes + 1);
  localparam int unsigned HeadBytes    = 6;
  localparam int unsigned HeadW        = $clog2(HeadBytes);
  localparam int unsigned ChunkBytes   = 5;
  localparam int unsigned ChunkW       = $clog2(ChunkBytes + 1);
  localparam int unsigned EndBytes     = 8;

  localparam logic [7:0] OpIndex = 8'h00;
  localparam logic [7:0] OpDiff  = 8'h40;
  localparam logic [7:0] OpLuma  = 8'h80;
  localparam logic [7:0] OpRun   = 8'hc0;
  localparam logic [7:0] OpRgb   = 8'hfe;
  localparam logic [7:0] OpRgba  = 8'hff;
  localparam logic [7:0] EndMark = 8'h01;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  localparam pixel_t PixelReset = '{a: 8'hff, b: 8'h00, g: 8'h00, r: 8'h00};

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } ser_load_t;

  function automatic logic [HashW-1:0] qoi_hash(pixel_t p);
    logic [HashW-1:0] s;
    s = p.r[HashW-1:0] * HashW'(3) + p.g[HashW-1:0] * HashW'(5) +
        p.b[HashW-1:0] * HashW'(7) + p.a[HashW-1:0] * HashW'(11);
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qpe_ram.sv
`default_nettype none

module qpe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/qpe_chunk.sv
`default_nettype none

module qpe_chunk import qpe_pkg::*; (
  input  wire pixel_t           px_i,
  input  wire logic             last_i,
  input  wire pixel_t           prev_i,
  input  wire logic [RunW-1:0]  run_i,
  input  wire logic [HashW-1:0] hash_i,
  input  wire logic             hit_i,
  output ser_load_t             ld_o,
  output logic [RunW-1:0]       run_o,
  output logic                  tbl_wr_o
);

  logic                           eq;
  logic [RunW-1:0]                run_nx;
  logic                           lead;
  logic [7:0]                     lead_byte;
  logic [ChunkBytes-1:0][7:0]     chunk;
  logic [ChunkW-1:0]              chunk_len;
  logic [HeadBytes-1:0][7:0]      head;
  logic [CntW-1:0]                head_len;
  logic                           tail_run;
  logic [CntW-1:0]                tail_len;
  logic [CntW-1:0]                pos;
  logic [CntW-1:0]                tpos;
  logic [7:0]                     dr, dg, db;
  logic [7:0]                     dro, dgo, dbo, dgl;
  logic [9:0]                     rgo, bgo;

  always_comb begin
    eq        = (px_i == prev_i);
    run_nx    = '0;
    lead      = 1'b0;
    lead_byte = '0;
    chunk     = '0;
    chunk_len = '0;
    dr  = px_i.r - prev_i.r;
    dg  = px_i.g - prev_i.g;
    db  = px_i.b - prev_i.b;
    dro = dr + 8'd2;
    dgo = dg + 8'd2;
    dbo = db + 8'd2;
    dgl = dg + 8'd32;
    rgo = {{2{dr[7]}}, dr} - {{2{dg[7]}}, dg} + 10'd8;
    bgo = {{2{db[7]}}, db} - {{2{dg[7]}}, dg} + 10'd8;

    if (eq) begin
      run_nx = run_i + RunW'(1);
      if (run_nx >= RunW'(MaxRun)) begin
        lead      = 1'b1;
        lead_byte = OpRun | {2'b00, run_i};
        run_nx    = '0;
      end
    end else begin
      lead      = (run_i != '0);
      lead_byte = OpRun | {2'b00, run_i - RunW'(1)};
      if (hit_i) begin
        chunk[0]  = OpIndex | {2'b00, hash_i};
        chunk_len = ChunkW'(1);
      end else if (px_i.a == prev_i.a) begin
        if (dro < 8'd4 && dgo < 8'd4 && dbo < 8'd4) begin
          chunk[0]  = OpDiff | {2'b00, dro[1:0], dgo[1:0], dbo[1:0]};
          chunk_len = ChunkW'(1);
        end else if (dgl < 8'd64 && rgo < 10'd16 && bgo < 10'd16) begin
          chunk[0]  = OpLuma | {2'b00, dgl[5:0]};
          chunk[1]  = {rgo[3:0], bgo[3:0]};
          chunk_len = ChunkW'(2);
        end else begin
          chunk[0]  = OpRgb;
          chunk[1]  = px_i.r;
          chunk[2]  = px_i.g;
          chunk[3]  = px_i.b;
          chunk_len = ChunkW'(4);
        end
      end else begin
        chunk[0]  = OpRgba;
        chunk[1]  = px_i.r;
        chunk[2]  = px_i.g;
        chunk[3]  = px_i.b;
        chunk[4]  = px_i.a;
        chunk_len = ChunkW'(5);
      end
    end

    head[0] = lead ? lead_byte : chunk[0];
    for (int k = 1; k < ChunkBytes; k++) begin
      head[k] = lead ? chunk[k-1] : chunk[k];
    end
    head[HeadBytes-1] = lead ? chunk[ChunkBytes-1] : 8'h00;
    head_len = CntW'(lead) + CntW'(chunk_len);

    tail_run = last_i && (run_nx != '0);
    tail_len = last_i ? (CntW'(EndBytes) + CntW'(tail_run)) : '0;

    for (int i = 0; i < MaxBytes; i++) begin
      pos  = CntW'(i);
      tpos = pos - head_len;
      if (pos < head_len) begin
        ld_o.bytes[i] = head[pos[HeadW-1:0]];
      end else if (tail_run && tpos == '0) begin
        ld_o.bytes[i] = OpRun | {2'b00, run_nx - RunW'(1)};
      end else if (last_i && tpos == tail_len - CntW'(1)) begin
        ld_o.bytes[i] = EndMark;
      end else begin
        ld_o.bytes[i] = 8'h00;
      end
    end
    ld_o.count = head_len + tail_len;

    run_o    = run_nx;
    tbl_wr_o = !eq && !hit_i;
  end

endmodule

`default_nettype wire

>>> rtl/qpe_serializer.sv
`default_nettype none

module qpe_serializer import qpe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      ld_vld_i,
  input  wire ser_load_t ld_i,
  output logic           free_o,
  output logic           m_axis_tvalid,
  input  wire logic      m_axis_tready,
  output logic [7:0]     m_axis_tdata,  // out_byte
  output logic           m_axis_tlast   // last_byte
);

  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     xfer;

  assign xfer   = m_axis_tvalid && m_axis_tready;
  assign free_o = (cnt_q == '0) || (cnt_q == CntW'(1) && m_axis_tready);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (ld_vld_i) begin
      buf_d = ld_i.bytes;
      cnt_d = ld_i.count;
    end else if (xfer) begin
      buf_d = buf_q >> 8;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = (cnt_q == CntW'(1));

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("byte count exceeds buffer");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_vld_i |-> (cnt_q == '0 || (cnt_q == CntW'(1) && m_axis_tready)))
    else $error("load over undelivered bytes");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !ld_vld_i) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("byte count did not advance on transfer");

  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_vld_i && ld_i.count != '0) |=> m_axis_tvalid)
    else $error("loaded bytes not presented");

endmodule

`default_nettype wire

>>> rtl/qoi_pixel_encoder_unit.sv
// QOI chunk encoder, one RGBA pixel in, a stream of chunk bytes out.
// Input channel s_axis: tdata carries red, green, blue, alpha (red lowest),
// tlast marks the last pixel of an image. Output channel m_axis: one byte of
// the chunk stream per transfer, tlast on the final byte caused by a pixel.
// A pixel that only extends a run produces no output transfer.
// A pixel accepted on s_axis is registered in the encode register and encoded
// there; its bytes go to the serializer buffer, from which m_axis offers them.
// Throughput: one pixel per cycle while m_axis is ready and each pixel gives
// at most one byte; the output port moves one byte per cycle while ready, so
// a pixel giving k bytes (up to 14: run, RGBA chunk and the 8-byte end marker)
// holds the next pixel in the encode register until its bytes nearly drain.
// The seen-pixel table is a 64-entry RAM read at the hash of the arriving
// pixel, with per-entry valid flops (an unwritten entry matches only the
// all-zero pixel) and a forward path for a write made at the same edge.
// Reset: previous pixel is opaque black, run length zero, table all zero.
// The same state returns after the end marker of each image.
// A stall on m_axis holds the current byte and, once the encode register is
// full, drops s_axis_tready; nothing is lost or repeated.
`default_nettype none

module qoi_pixel_encoder_unit import qpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // red, green, blue, alpha
  input  wire logic        s_axis_tlast,  // last_pixel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte
  output logic             m_axis_tlast   // last_byte
);

  pixel_t                  s_px;
  logic [HashW-1:0]        s_hash;
  logic                    s_acc;

  logic                    a_vld_q;
  pixel_t                  a_px_q;
  logic                    a_last_q;
  logic [HashW-1:0]        a_hash_q;
  logic                    byp_q;
  pixel_t                  byp_px_q;
  logic                    a_adv;

  pixel_t                  prev_q;
  logic [RunW-1:0]         run_q;
  logic [TableEntries-1:0] seen_vld_q;

  logic [31:0]             ram_rdata;
  pixel_t                  tbl_px;
  logic                    hit;
  logic                    tbl_we;

  ser_load_t               ld;
  logic [RunW-1:0]         run_nx;
  logic                    tbl_wr;
  logic                    ser_free;

  assign s_px   = pixel_t'(s_axis_tdata);
  assign s_hash = qoi_hash(s_px);

  assign a_adv         = a_vld_q && (ld.count == '0 || ser_free);
  assign s_axis_tready = !a_vld_q || a_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign tbl_we        = a_adv && tbl_wr && !a_last_q;

  qpe_ram #(
    .Width (32),
    .Depth (TableEntries)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (a_hash_q),
    .wdata_i (a_px_q),
    .re_i    (s_acc),
    .raddr_i (s_hash),
    .rdata_o (ram_rdata)
  );

  assign tbl_px = byp_q ? byp_px_q : pixel_t'(ram_rdata);
  assign hit    = (byp_q || seen_vld_q[a_hash_q]) ? (tbl_px == a_px_q) : (a_px_q == '0);

  qpe_chunk u_chunk (
    .px_i     (a_px_q),
    .last_i   (a_last_q),
    .prev_i   (prev_q),
    .run_i    (run_q),
    .hash_i   (a_hash_q),
    .hit_i    (hit),
    .ld_o     (ld),
    .run_o    (run_nx),
    .tbl_wr_o (tbl_wr)
  );

  qpe_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ld_vld_i      (a_adv && ld.count != '0),
    .ld_i          (ld),
    .free_o        (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q    <= 1'b0;
      byp_q      <= 1'b0;
      prev_q     <= PixelReset;
      run_q      <= '0;
      seen_vld_q <= '0;
    end else begin
      if (s_acc) begin
        a_vld_q <= 1'b1;
        byp_q   <= tbl_we && (a_hash_q == s_hash);
      end else if (a_adv) begin
        a_vld_q <= 1'b0;
      end
      if (a_adv) begin
        if (a_last_q) begin
          prev_q     <= PixelReset;
          run_q      <= '0;
          seen_vld_q <= '0;
        end else begin
          prev_q <= a_px_q;
          run_q  <= run_nx;
          if (tbl_wr) begin
            seen_vld_q[a_hash_q] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_px_q   <= s_px;
      a_last_q <= s_axis_tlast;
      a_hash_q <= s_hash;
      byp_px_q <= a_px_q;
    end
  end

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q < RunW'(MaxRun))
    else $error("run length reached flush limit unflushed");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_last_q) |=> (run_q == '0 && seen_vld_q == '0))
    else $error("state not cleared after last pixel");

  a_byp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && byp_q) |-> seen_vld_q[a_hash_q])
    else $error("forwarded entry not marked valid");

endmodule

`default_nettype wire
